// ===== design/decimal_money_to_pennies_parser_defines.svh =====
// Assertion helpers for the parser RTL.
`ifndef DECIMAL_MONEY_TO_PENNIES_PARSER_DEFINES_SVH
`define DECIMAL_MONEY_TO_PENNIES_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("parser check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("parser check failed in the next cycle");

`endif

// ===== design/dmp_pkg.sv =====
`default_nettype none

package dmp_pkg;

  localparam int MagBits    = 47;
  localparam int FracDigits = 2;
  localparam int PenniesW   = 48;
  localparam int FracCntW   = $clog2(FracDigits + 1);
  localparam int PushW      = MagBits + 4;
  localparam int ScaleW     = 10;
  localparam int ScaledW    = MagBits + ScaleW;
  localparam int ExtW       = (MagBits >= PenniesW) ? MagBits : PenniesW;

  localparam logic [MagBits-1:0] MagLimit = {MagBits{1'b1}};

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    PhaseSign = 2'd0,
    PhaseInt  = 2'd1,
    PhaseFrac = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       ends_here;
    logic       flip_sign;
  } in_word_t;

  typedef struct packed {
    logic                       amount_valid;
    logic signed [PenniesW-1:0] pennies;
    logic                       overflowed;
  } out_word_t;

  typedef struct packed {
    phase_e                phase;
    logic                  saw_minus;
    logic                  saw_nonzero;
    logic [FracCntW-1:0]   frac_count;
    logic                  bad_text;
    logic [MagBits-1:0]    acc;
    logic                  ovf;
  } state_t;

  localparam state_t StateReset = '{
    phase:       PhaseSign,
    saw_minus:   1'b0,
    saw_nonzero: 1'b0,
    frac_count:  '0,
    bad_text:    1'b0,
    acc:         '0,
    ovf:         1'b0
  };

  // Power of ten for up to three missing fraction digits.
  function automatic logic [ScaleW-1:0] pow10(input logic [FracCntW-1:0] k);
    logic [ScaleW-1:0] r;
    case (k)
      FracCntW'(0): r = ScaleW'(1);
      FracCntW'(1): r = ScaleW'(10);
      FracCntW'(2): r = ScaleW'(100);
      FracCntW'(3): r = ScaleW'(1000);
      default:      r = ScaleW'(1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/dmp_char_step.sv =====
`default_nettype none

module dmp_char_step (
  input  dmp_pkg::state_t cur_i,
  input  logic [7:0]      char_i,
  output dmp_pkg::state_t nxt_o
);
  import dmp_pkg::*;

  logic              is_digit;
  logic [3:0]        digit;
  logic [PushW-1:0]  pushed;
  logic              push_sat;
  logic [MagBits-1:0] push_acc;

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign digit    = 4'(char_i - CharZero);

  // Times ten as two shifts, then the digit; saturate at the magnitude limit.
  assign pushed   = (PushW'(cur_i.acc) << 3) + (PushW'(cur_i.acc) << 1) + PushW'(digit);
  assign push_sat = pushed > PushW'(MagLimit);
  assign push_acc = push_sat ? MagLimit : pushed[MagBits-1:0];

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.bad_text) begin
      if (char_i == CharMinus) begin
        if (cur_i.phase == PhaseSign) begin
          nxt_o.saw_minus = 1'b1;
          nxt_o.phase     = PhaseInt;
        end else begin
          nxt_o.bad_text = 1'b1;
        end
      end else if (char_i == CharPoint) begin
        if (cur_i.phase != PhaseFrac) begin
          nxt_o.phase = PhaseFrac;
        end else begin
          nxt_o.bad_text = 1'b1;
        end
      end else if (is_digit) begin
        if (cur_i.phase != PhaseFrac) begin
          // A leading zero only moves on to the integer digits.
          if ((digit != 4'd0) || (cur_i.phase == PhaseInt)) begin
            nxt_o.acc = push_acc;
            nxt_o.ovf = cur_i.ovf | push_sat;
            if (digit != 4'd0) begin
              nxt_o.saw_nonzero = 1'b1;
            end
          end
          nxt_o.phase = PhaseInt;
        end else if (cur_i.frac_count < FracCntW'(FracDigits)) begin
          nxt_o.acc        = push_acc;
          nxt_o.ovf        = cur_i.ovf | push_sat;
          nxt_o.frac_count = cur_i.frac_count + FracCntW'(1);
          if (digit != 4'd0) begin
            nxt_o.saw_nonzero = 1'b1;
          end
        end
      end else begin
        nxt_o.bad_text = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dmp_finish.sv =====
`default_nettype none

module dmp_finish (
  input  dmp_pkg::state_t    cur_i,
  input  logic               flip_i,
  output dmp_pkg::out_word_t res_o
);
  import dmp_pkg::*;

  logic                valid;
  logic [FracCntW-1:0] missing;
  logic [ScaledW-1:0]  scaled;
  logic                scale_sat;
  logic [MagBits-1:0]  mag;
  logic [ExtW-1:0]     ext;
  logic [ExtW-1:0]     signed_ext;

  assign valid = !cur_i.bad_text && cur_i.saw_nonzero;

  // Missing fraction digits are filled with zeros by a constant scale for each count.
  assign missing = FracCntW'(FracDigits) - cur_i.frac_count;

  always_comb begin
    case (missing)
      FracCntW'(0): scaled = ScaledW'(cur_i.acc);
      FracCntW'(1): scaled = ScaledW'(cur_i.acc) * ScaledW'(pow10(FracCntW'(1)));
      FracCntW'(2): scaled = ScaledW'(cur_i.acc) * ScaledW'(pow10(FracCntW'(2)));
      FracCntW'(3): scaled = ScaledW'(cur_i.acc) * ScaledW'(pow10(FracCntW'(3)));
      default:      scaled = ScaledW'(cur_i.acc);
    endcase
  end

  assign scale_sat = scaled > ScaledW'(MagLimit);
  assign mag       = scale_sat ? MagLimit : scaled[MagBits-1:0];

  assign ext        = ExtW'(mag);
  assign signed_ext = (flip_i != cur_i.saw_minus) ? (ExtW'(0) - ext) : ext;

  always_comb begin
    res_o.amount_valid = valid;
    res_o.pennies      = valid ? signed_ext[PenniesW-1:0] : '0;
    res_o.overflowed   = valid && (cur_i.ovf || scale_sat);
  end

endmodule

`default_nettype wire

// ===== design/decimal_money_to_pennies_parser.sv =====
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o   | dmp_pkg::in_word_t
// out     | output    | out_valid_o / out_ready_i | dmp_pkg::out_word_t
//
// Each word is held in the input register and parsed from there.
// A new word is taken every cycle unless an end word waits for a full result register.
// An end word goes from the input register into the result register once that register is free.
// Reset clears the parse state and both valid flags.
// Only an end word waits for a full result register; characters keep flowing.
`default_nettype none

`include "decimal_money_to_pennies_parser_defines.svh"

module decimal_money_to_pennies_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dmp_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmp_pkg::out_word_t out_data_o
);
  import dmp_pkg::*;

  in_word_t  in_q;
  logic      in_valid_q;
  state_t    state_q, state_d;
  out_word_t out_q;
  logic      out_valid_q;

  state_t    step_nxt;
  out_word_t fin_res;
  logic      out_free;
  logic      advance;
  logic      take_in;
  logic      load_out;

  dmp_char_step u_char_step (
    .cur_i  (state_q),
    .char_i (in_q.char_code),
    .nxt_o  (step_nxt)
  );

  dmp_finish u_finish (
    .cur_i  (state_q),
    .flip_i (in_q.flip_sign),
    .res_o  (fin_res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_q.ends_here || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign take_in    = in_valid_i && in_ready_o;
  assign load_out   = advance && in_q.ends_here;

  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = in_q.ends_here ? StateReset : step_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      state_q <= state_d;
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= fin_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DMP_ASSERT_SAME(a_empty_is_zero, out_valid_q && !out_q.amount_valid,
                   (out_q.pennies == '0) && !out_q.overflowed)
  `DMP_ASSERT_NEXT(a_end_waits, in_valid_q && in_q.ends_here && out_valid_q && !out_ready_i,
                   in_valid_q && in_q.ends_here)
  `DMP_ASSERT_NEXT(a_char_no_result, advance && !in_q.ends_here && !out_valid_q,
                   !out_valid_q)
  `DMP_ASSERT_NEXT(a_bad_holds_acc, advance && !in_q.ends_here && state_q.bad_text,
                   $stable(state_q.acc) && state_q.bad_text)

endmodule

`default_nettype wire
